// ----- rtl/lihc_pkg.sv -----
package lihc_pkg;

  // log10 result, signed Q6.16
  localparam int LOG_W = 23;
  typedef logic signed [LOG_W-1:0] log_t;

  // scaled hue position, (1-s)*5 in Q.40
  localparam int HP_W = 43;
  typedef logic [HP_W-1:0] hp_t;

  localparam int LOG_FLOOR_Q16 = -655360;   // -10.0
  localparam int LOG_SAT_Q16   = 4194303;   // largest Q6.16 value
  localparam int LOG10_2_Q30   = 323228497; // log10(2) in Q0.30

  // register stages from input to output register
  localparam int PIPE_STAGES = 7;

  // log2(1 + idx/2^tb) in Q.fb, floored, by repeated squaring in Q2.30
  function automatic logic [63:0] rom_log2(input int unsigned idx, input int tb,
                                           input int fb);
    logic [63:0] y;
    logic [63:0] r;
    int          i;
    y = (64'd1 << 30) + (64'(idx) << (30 - tb));
    r = '0;
    for (i = 0; i < fb; i++) begin
      y = (y * y) >> 30;
      r = r << 1;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        r = r | 64'd1;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/lihc_log10.sv -----
module lihc_log10 #(
  parameter int LOG_TABLE_BITS = 8,
  parameter int LOG_FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic [2:0]        stage_en,
  input  logic [31:0]       intensity_bits,
  output lihc_pkg::log_t    lg
);
  import lihc_pkg::*;

  localparam int ROM_DEPTH = 2 ** LOG_TABLE_BITS;
  localparam int L2W       = LOG_FRAC_BITS + 8;
  localparam int PW        = L2W + 31;
  localparam int SH        = LOG_FRAC_BITS + 14;
  localparam int VW        = PW - SH;

  localparam logic signed [VW-1:0] V_FLOOR = VW'(LOG_FLOOR_Q16);
  localparam logic signed [VW-1:0] V_SAT   = VW'(LOG_SAT_Q16);

  typedef enum logic [1:0] {CLS_NORMAL, CLS_FLOOR, CLS_SAT} cls_t;

  logic [LOG_FRAC_BITS-1:0] rom_c [ROM_DEPTH];

  genvar g;
  for (g = 0; g < ROM_DEPTH; g++) begin : g_rom
    assign rom_c[g] = LOG_FRAC_BITS'(rom_log2(g, LOG_TABLE_BITS, LOG_FRAC_BITS));
  end

  // stage 1: classify, unbias exponent, mantissa lookup
  logic                      sign_c;
  logic [7:0]                e_c;
  logic [22:0]               mant_c;
  logic [LOG_TABLE_BITS-1:0] idx_c;
  cls_t                      cls_nxt;
  logic [7:0]                exp_nxt;

  assign sign_c = intensity_bits[31];
  assign e_c    = intensity_bits[30:23];
  assign mant_c = intensity_bits[22:0];
  assign idx_c  = mant_c[22 -: LOG_TABLE_BITS];

  always_comb begin
    exp_nxt = 8'({1'b0, e_c} - 9'd127);
    if (e_c == 8'hFF) begin
      cls_nxt = (mant_c != '0 || !sign_c) ? CLS_SAT : CLS_FLOOR;
    end else if (sign_c || e_c == 8'h00) begin
      cls_nxt = CLS_FLOOR;
    end else begin
      cls_nxt = CLS_NORMAL;
    end
  end

  cls_t                     cls1_r;
  logic signed [7:0]        exp_r;
  logic [LOG_FRAC_BITS-1:0] rom_r;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      cls1_r <= cls_nxt;
      exp_r  <= exp_nxt;
      rom_r  <= rom_c[idx_c];
    end
  end

  // stage 2: log2 times log10(2)
  logic signed [L2W-1:0] l2_c;
  logic signed [PW-1:0]  prod_nxt;

  assign l2_c     = {exp_r, rom_r};
  assign prod_nxt = PW'(l2_c) * PW'(LOG10_2_Q30);

  cls_t                 cls2_r;
  logic signed [PW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      cls2_r <= cls1_r;
      prod_r <= prod_nxt;
    end
  end

  // stage 3: floor to Q.16 (arithmetic shift), clamp, special values
  logic signed [VW-1:0] v_c;
  logic signed [VW-1:0] vcl_c;
  log_t                 lg_nxt;

  assign v_c = prod_r[PW-1:SH];

  always_comb begin
    if (v_c < V_FLOOR) begin
      vcl_c = V_FLOOR;
    end else if (v_c > V_SAT) begin
      vcl_c = V_SAT;
    end else begin
      vcl_c = v_c;
    end
    case (cls2_r)
      CLS_SAT:   lg_nxt = LOG_W'(LOG_SAT_Q16);
      CLS_FLOOR: lg_nxt = LOG_W'(LOG_FLOOR_Q16);
      default:   lg_nxt = vcl_c[LOG_W-1:0];
    endcase
  end

  log_t lg_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      lg_r <= lg_nxt;
    end
  end

  assign lg = lg_r;

endmodule

// ----- rtl/lihc_scale.sv -----
module lihc_scale (
  input  logic           clk,
  input  logic [2:0]     stage_en,
  input  lihc_pkg::log_t lg,
  input  lihc_pkg::log_t min_log,
  input  logic [31:0]    span_recip,
  output lihc_pkg::hp_t  hp
);
  import lihc_pkg::*;

  localparam int DW = LOG_W;       // positive difference fits here
  localparam int SW = DW + 32;
  localparam logic [40:0] S_ONE = 41'(64'd1 << 40);

  // stage 4: difference to frame minimum, zero when not above it
  logic signed [LOG_W+1:0] d_c;
  logic [DW-1:0]           d_nxt;

  assign d_c   = (LOG_W+2)'(lg) - (LOG_W+2)'(min_log);
  assign d_nxt = (d_c > 0) ? d_c[DW-1:0] : '0;

  logic [DW-1:0] d_r;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      d_r <= d_nxt;
    end
  end

  // stage 5: times reciprocal span, Q.40
  logic [SW-1:0] s_nxt;
  logic [SW-1:0] s_r;

  assign s_nxt = SW'(d_r) * SW'(span_recip);

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s_r <= s_nxt;
    end
  end

  // stage 6: saturate to 1.0, hp = (1 - s) * 5
  logic [40:0] ssat_c;
  logic [40:0] t_c;
  hp_t         hp_nxt;

  assign ssat_c = (s_r > SW'(S_ONE)) ? S_ONE : s_r[40:0];
  assign t_c    = S_ONE - ssat_c;
  assign hp_nxt = {t_c, 2'b00} + HP_W'(t_c);

  hp_t hp_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      hp_r <= hp_nxt;
    end
  end

  assign hp = hp_r;

endmodule

// ----- rtl/lihc_hue.sv -----
module lihc_hue (
  input  logic          clk,
  input  logic          stage_en,
  input  lihc_pkg::hp_t hp,
  output logic [7:0]    red,
  output logic [7:0]    green,
  output logic [7:0]    blue
);
  import lihc_pkg::*;

  localparam hp_t HP_1 = HP_W'(64'd1 << 40);
  localparam hp_t HP_2 = HP_W'(64'd2 << 40);
  localparam hp_t HP_3 = HP_W'(64'd3 << 40);
  localparam hp_t HP_4 = HP_W'(64'd4 << 40);
  localparam logic [41:0] TWO_Q = 42'(64'd1 << 41);

  // triangle ramp: f = 1 - |hp mod 2 - 1|, mod 2 is the low 41 bits
  logic [40:0] m_c;
  logic [40:0] f_c;
  logic [48:0] f255_c;
  logic [7:0]  x_c;

  assign m_c    = hp[40:0];
  assign f_c    = m_c[40] ? 41'(TWO_Q - 42'(m_c)) : m_c;
  assign f255_c = {f_c, 8'h00} - 49'(f_c);
  assign x_c    = f255_c[47:40];

  logic [7:0] red_nxt;
  logic [7:0] green_nxt;
  logic [7:0] blue_nxt;

  // segment edges fall into the lower segment
  always_comb begin
    if (hp <= HP_1) begin
      red_nxt = 8'hFF; green_nxt = x_c;   blue_nxt = 8'h00;
    end else if (hp <= HP_2) begin
      red_nxt = x_c;   green_nxt = 8'hFF; blue_nxt = 8'h00;
    end else if (hp <= HP_3) begin
      red_nxt = 8'h00; green_nxt = 8'hFF; blue_nxt = x_c;
    end else if (hp <= HP_4) begin
      red_nxt = 8'h00; green_nxt = x_c;   blue_nxt = 8'hFF;
    end else begin
      red_nxt = x_c;   green_nxt = 8'h00; blue_nxt = 8'hFF;
    end
  end

  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;

  always_ff @(posedge clk) begin
    if (stage_en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

// ----- rtl/log_intensity_hue_colormap_core.sv -----
// Log-intensity heatmap colouriser: one IEEE single sample in, one RGB pixel out.
//
// Input channel in_*: in_intensity_bits carries the sample's bit pattern; an
// item is taken on a clock edge with in_valid high and in_stall low.
// Output channel out_*: out_red/out_green/out_blue, taken when out_valid is
// high and out_stall low. One pixel per sample, in order.
// Config (APB, pready tied high): 0x0 min_log (signed Q6.16, sign-extended on
// read), 0x4 span_recip (unsigned Q8.24). Write only while the pipe is empty.
//
// Throughput: one item per cycle while in_stall is low, set by the seven-stage
// pipe (table lookup, log multiply, clamp, subtract, span multiply, saturate,
// colour select); out_valid rises once an item reaches the last stage.
// Reset (rst_n low, synchronous): all stage valids clear, min_log = -10.0,
// span_recip = 1.0.
// Stall: each stage moves on when its successor is free, so bubbles close up
// behind a stalled output; in_stall rises only once all seven stages hold an
// item and out_stall is high. Held items and the output payload do not change.
module log_intensity_hue_colormap_core #(
  parameter int LOG_TABLE_BITS = 8,
  parameter int LOG_FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_intensity_bits,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lihc_pkg::*;

  // register select, byte address bit 2
  localparam logic REG_MIN_LOG    = 1'b0;
  localparam logic REG_SPAN_RECIP = 1'b1;

  localparam logic [31:0] SPAN_RESET = 32'h0100_0000;  // 1.0 in Q8.24

  // ---------------- config registers ----------------
  log_t        min_log_r;
  logic [31:0] span_recip_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_log_r    <= LOG_W'(LOG_FLOOR_Q16);
      span_recip_r <= SPAN_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MIN_LOG:    min_log_r    <= pwdata[LOG_W-1:0];
        REG_SPAN_RECIP: span_recip_r <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_LOG:    prdata = 32'(min_log_r);
      REG_SPAN_RECIP: prdata = span_recip_r;
      default:        prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // stage k loads when it is empty or stage k+1 loads too
  logic [PIPE_STAGES-1:0] valid_r;
  logic [PIPE_STAGES-1:0] valid_nxt;
  logic [PIPE_STAGES-1:0] ready;

  always_comb begin
    ready[PIPE_STAGES-1] = !valid_r[PIPE_STAGES-1] || !out_stall;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_nxt[0] = ready[0] ? in_valid : valid_r[0];
    for (int k = 1; k < PIPE_STAGES; k++) begin
      valid_nxt[k] = ready[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = valid_r[PIPE_STAGES-1];

  // ---------------- datapath ----------------
  log_t lg;
  hp_t  hp;

  // stages 1-3: log10 in Q6.16
  lihc_log10 #(
    .LOG_TABLE_BITS (LOG_TABLE_BITS),
    .LOG_FRAC_BITS  (LOG_FRAC_BITS)
  ) u_log10 (
    .clk            (clk),
    .stage_en       (ready[2:0]),
    .intensity_bits (in_intensity_bits),
    .lg             (lg)
  );

  // stages 4-6: normalise against frame range, hue position
  lihc_scale u_scale (
    .clk        (clk),
    .stage_en   (ready[5:3]),
    .lg         (lg),
    .min_log    (min_log_r),
    .span_recip (span_recip_r),
    .hp         (hp)
  );

  // stage 7: segment and ramp, output register
  lihc_hue u_hue (
    .clk      (clk),
    .stage_en (ready[6]),
    .hp       (hp),
    .red      (out_red),
    .green    (out_green),
    .blue     (out_blue)
  );

  // ---------------- checks ----------------
  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // input back-pressure only with a full pipe behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&valid_r) && out_stall))
    else $error("in_stall raised with a bubble in the pipe");

  // items in flight change only by accepted inputs and outputs
  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(valid_r) ==
      $countones($past(valid_r)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("item lost or invented in the pipe");

  // every hue has one full and one empty channel
  a_hue_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_red == 8'hFF || out_green == 8'hFF || out_blue == 8'hFF) &&
                   (out_red == 8'h00 || out_green == 8'h00 || out_blue == 8'h00)))
    else $error("pixel is not a saturated hue");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import lihc_pkg::*;

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int LUT_BITS       = 8;    // mantissa bits that index the log2 table
  localparam int FRAC_BITS      = 16;   // fraction bits of the table entries
  localparam int RAND_PHASES    = 10;   // config settings visited by the random part
  localparam int PHASE_ITEMS    = 110;  // items per random phase
  localparam int HOLD_PHASE     = 3;    // phase in which the receiver holds off
  localparam int HOLD_CYCLES    = 80;   // length of that hold-off
  localparam int WATCHDOG_LIMIT = 3000; // cycles without any handshake

  localparam logic [63:0] ONE_Q40 = 64'd1 << 40;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam rgb_t MAGENTA = '{8'hFF, 8'h00, 8'hFF};
  localparam rgb_t RED     = '{8'hFF, 8'h00, 8'h00};

  // register index, also bits [2] of paddr
  typedef enum logic [0:0] {
    REG_MIN_LOG    = 1'b0,
    REG_SPAN_RECIP = 1'b1
  } cfg_reg_t;

  // directed table row: one item, or one register write
  typedef enum logic [1:0] {
    ROW_PIX,
    ROW_MIN,
    ROW_SPAN
  } row_t;

  typedef struct packed {
    row_t        kind;
    logic [31:0] val;
    logic        chk;  // 1: use the typed-in colour, 0: use the predictor
    rgb_t        want;
  } step_t;

  localparam int DIR_ROWS = 31;

  // Directed part. Rows up to the first write run with reset config
  // (min_log -10.0, span_recip 1.0).
  step_t dir_tab [DIR_ROWS] = '{
    '{ROW_PIX,  32'h0000_0000, 1'b1, MAGENTA}, // +0
    '{ROW_PIX,  32'h8000_0000, 1'b1, MAGENTA}, // -0
    '{ROW_PIX,  32'h0000_0001, 1'b1, MAGENTA}, // smallest subnormal
    '{ROW_PIX,  32'h807F_FFFF, 1'b1, MAGENTA}, // negative subnormal
    '{ROW_PIX,  32'hBF80_0000, 1'b1, MAGENTA}, // -1.0
    '{ROW_PIX,  32'hFF80_0000, 1'b1, MAGENTA}, // -inf
    '{ROW_PIX,  32'h0080_0000, 1'b1, MAGENTA}, // smallest normal, log clamped at -10
    '{ROW_PIX,  32'h7F80_0000, 1'b1, RED},     // +inf saturates
    '{ROW_PIX,  32'h7FC0_0000, 1'b1, RED},     // quiet NaN
    '{ROW_PIX,  32'hFFFF_FFFF, 1'b1, RED},     // negative NaN
    '{ROW_PIX,  32'h2EDB_E6FF, 1'b0, '0},      // about 1e-10, right at the floor
    '{ROW_PIX,  32'h7F7F_FFFF, 1'b0, '0},      // largest finite
    '{ROW_MIN,  32'hFFFF_0000, 1'b0, '0},      // min_log -1.0
    '{ROW_SPAN, 32'h0100_0000, 1'b0, '0},      // span 1.0
    '{ROW_PIX,  32'h3F80_0000, 1'b1, RED},     // 1.0: product exactly 1.0
    '{ROW_PIX,  32'h3DCC_CCCD, 1'b0, '0},      // 0.1: at the minimum
    '{ROW_PIX,  32'h3F00_0000, 1'b0, '0},      // 0.5: mid ramp
    '{ROW_SPAN, 32'h0000_0000, 1'b0, '0},      // zero span
    '{ROW_PIX,  32'h7F7F_FFFF, 1'b1, MAGENTA},
    '{ROW_PIX,  32'h7F80_0000, 1'b1, MAGENTA},
    '{ROW_MIN,  32'h0027_0000, 1'b0, '0},      // min_log 39.0, top of range
    '{ROW_SPAN, 32'hFFFF_FFFF, 1'b0, '0},      // largest span
    '{ROW_PIX,  32'h7F7F_FFFF, 1'b0, '0},      // below the minimum
    '{ROW_PIX,  32'h7F80_0000, 1'b1, RED},
    '{ROW_PIX,  32'h7FFF_FFFF, 1'b1, RED},
    '{ROW_MIN,  32'hFFF6_0000, 1'b0, '0},      // min_log -10.0
    '{ROW_SPAN, 32'h0008_0000, 1'b0, '0},      // 1/32
    '{ROW_PIX,  32'h3F80_0000, 1'b0, '0},      // 1.0
    '{ROW_PIX,  32'h5015_02F9, 1'b0, '0},      // 1e10
    '{ROW_PIX,  32'h1E3C_E508, 1'b0, '0},      // 1e-20
    '{ROW_PIX,  32'h4CBE_BC20, 1'b0, '0}       // 1e8
  };

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_intensity_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk = ~clk;

  log_intensity_hue_colormap_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_intensity_bits (in_intensity_bits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: bench copy of the two registers plus the log2 table
  // ---------------------------------------------------------------------------
  logic signed [22:0] min_log_q = 23'(LOG_FLOOR_Q16);
  logic [31:0]        span_q    = 32'h0100_0000;
  logic [63:0]        mant_log2 [1 << LUT_BITS];

  rgb_t        want_pixels [$];   // colours still owed by the DUT, oldest first
  int unsigned bad_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b1;    // both sides stop idling while set
  bit          hold_req = 1'b0;   // asks the receiver for one long hold-off

  // log10 of the sample in signed Q6.16, clamped to [-10, largest]
  function automatic logic signed [22:0] log10_fixed(input logic [31:0] bits);
    logic [7:0]  ex;
    logic [22:0] man;
    longint      l2;
    longint      prod;
    longint      v;
    ex  = bits[30:23];
    man = bits[22:0];
    if (ex == 8'hFF)
      return (man != '0 || !bits[31]) ? 23'(LOG_SAT_Q16) : 23'(LOG_FLOOR_Q16);
    if (bits[31] || ex == 8'h00)
      return 23'(LOG_FLOOR_Q16);
    l2 = (longint'(ex) - 127) * (longint'(1) << FRAC_BITS)
       + longint'(mant_log2[man[22 -: LUT_BITS]]);
    prod = l2 * longint'(LOG10_2_Q30);
    v = prod >>> (FRAC_BITS + 14);   // arithmetic shift floors towards -inf
    if (v < LOG_FLOOR_Q16) v = longint'(LOG_FLOOR_Q16);
    if (v > LOG_SAT_Q16)   v = longint'(LOG_SAT_Q16);
    return v[22:0];
  endfunction

  // full pixel for one sample under the current register copy
  function automatic rgb_t colour_of(input logic [31:0] bits);
    longint      d;
    logic [63:0] s;
    logic [63:0] hp;
    logic [63:0] m;
    logic [63:0] f;
    logic [7:0]  x;
    rgb_t        c;
    d = longint'(log10_fixed(bits)) - longint'(min_log_q);
    s = (d <= 0) ? 64'd0 : unsigned'(d) * {32'd0, span_q};
    if (s > ONE_Q40) s = ONE_Q40;
    // hue / 60 degrees in Q.40, then the triangular ramp within the segment
    hp = (ONE_Q40 - s) * 5;
    m  = hp % (2 * ONE_Q40);
    f  = (m >= ONE_Q40) ? (2 * ONE_Q40 - m) : m;
    x  = 8'((f * 255) >> 40);
    if (hp <= ONE_Q40)          c = '{8'hFF, x, 8'h00};
    else if (hp <= 2 * ONE_Q40) c = '{x, 8'hFF, 8'h00};
    else if (hp <= 3 * ONE_Q40) c = '{8'h00, 8'hFF, x};
    else if (hp <= 4 * ONE_Q40) c = '{8'h00, x, 8'hFF};
    else                        c = '{x, 8'h00, 8'hFF};
    return c;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    bad_cnt++;
    if (bad_cnt <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // Offer one item and hold it until taken; the colour is owed from the
  // accepting edge on. Returns at that edge, so a following call keeps valid high.
  task automatic send_pixel(input logic [31:0] bits, input logic chk, input rgb_t want);
    in_valid          <= 1'b1;
    in_intensity_bits <= bits;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    want_pixels.push_back(chk ? want : colour_of(bits));
  endtask

  // APB write then read-back; only called with the pipe drained.
  task automatic cfg_write(input cfg_reg_t which, input logic [31:0] val);
    in_valid <= 1'b0;
    while (want_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (which == REG_MIN_LOG) min_log_q = val[22:0];
    else                      span_q    = val;
    // read-back, setup phase then access phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (which == REG_MIN_LOG) begin
      if (prdata[22:0] !== min_log_q)
        flag_mismatch("min_log read-back", {9'd0, min_log_q}, {9'd0, prdata[22:0]});
    end else begin
      if (prdata !== span_q)
        flag_mismatch("span_recip read-back", span_q, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor: every pixel taken is matched against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_check
    rgb_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (want_pixels.size() == 0) begin
        flag_mismatch("unexpected pixel", 32'd0, {8'd0, out_red, out_green, out_blue});
      end else begin
        want = want_pixels.pop_front();
        if (out_red !== want.r)   flag_mismatch("red", 32'(want.r), 32'(out_red));
        if (out_green !== want.g) flag_mismatch("green", 32'(want.g), 32'(out_green));
        if (out_blue !== want.b)  flag_mismatch("blue", 32'(want.b), 32'(out_blue));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request so the
  // pipe fills up and in_stall has to rise
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles with no handshake on any port
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned idx;
    int unsigned k;
    int unsigned ph;
    int unsigned gap;
    logic [63:0] y;
    logic [63:0] r;
    logic [31:0] bits;
    longint      lmin;
    longint      lrange;
    longint      target;
    int          ex;

    // log2(1 + idx/2^LUT_BITS) in Q.16 by repeated squaring in Q2.30
    for (idx = 0; idx < (1 << LUT_BITS); idx++) begin
      y = (64'd1 << 30) + (64'(idx) << (30 - LUT_BITS));
      r = '0;
      repeat (FRAC_BITS) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          r = r | 64'd1;
        end
      end
      mant_log2[idx] = r;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed table
    for (idx = 0; idx < DIR_ROWS; idx++) begin
      case (dir_tab[idx].kind)
        ROW_PIX: send_pixel(dir_tab[idx].val, dir_tab[idx].chk, dir_tab[idx].want);
        ROW_MIN: cfg_write(REG_MIN_LOG, dir_tab[idx].val);
        default: cfg_write(REG_SPAN_RECIP, dir_tab[idx].val);
      endcase
    end

    // random phases, each under its own register setting
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 1) begin
        lmin   = longint'(LOG_FLOOR_Q16);  // extremes: lowest minimum, largest span
        lrange = longint'(1 << 14);
        cfg_write(REG_MIN_LOG, 32'(LOG_FLOOR_Q16));
        cfg_write(REG_SPAN_RECIP, 32'hFFFF_FFFF);
      end else if (ph == 2) begin
        lmin   = longint'(2555904);        // top minimum, smallest non-zero span
        lrange = longint'(1 << 24);
        cfg_write(REG_MIN_LOG, 32'd2555904);
        cfg_write(REG_SPAN_RECIP, 32'd1);
      end else begin
        lmin   = longint'($urandom_range(0, 2555904 + 655360)) - 655360;
        lrange = longint'($urandom_range(1 << 14, 48 << 16));
        cfg_write(REG_MIN_LOG, 32'(lmin));
        if ($urandom_range(0, 3) == 0) cfg_write(REG_SPAN_RECIP, $urandom());
        else cfg_write(REG_SPAN_RECIP, 32'(ONE_Q40 / lrange));
      end
      // quiet phases: the hold-off phase, the last one, and some at random
      no_idle = (ph == HOLD_PHASE) || (ph == RAND_PHASES - 1) || ($urandom_range(0, 3) == 0);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == HOLD_PHASE && k == 10) hold_req = 1'b1;
        case ($urandom_range(0, 19))
          0, 1, 2: bits = $urandom();
          3: bits = {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom())}; // zero, subnormal
          4: bits = {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};            // infinities
          5: bits = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom()) | 23'd1}; // NaN
          default: begin
            // positive normal whose log lands around the current window
            target = lmin - lrange / 8 + longint'($urandom_range(0, 32'(lrange * 5 / 4)));
            ex = 127 + int'((target * 217706) >>> 32) + int'($urandom_range(0, 2)) - 1;
            if (ex < 1)   ex = 1;
            if (ex > 254) ex = 254;
            bits = {1'b0, 8'(ex), 23'($urandom())};
          end
        endcase
        send_pixel(bits, 1'b0, '0);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
          gap = $urandom_range(1, 13);
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // drain, then give the pipe time to show any stray pixel
    in_valid <= 1'b0;
    while (want_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_STAGES + 4) @(posedge clk);

    if (bad_cnt == 0 && want_pixels.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- log_intensity_hue_colormap_core.f -----
rtl/lihc_pkg.sv
rtl/lihc_log10.sv
rtl/lihc_scale.sv
rtl/lihc_hue.sv
rtl/log_intensity_hue_colormap_core.sv
tb/sv/tb.sv
